// ===== sv/v3a_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the 3D vector arithmetic unit.
package v3a_pkg;

  // Number format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;               // vector component width
  localparam int OPW       = DW + 1;           // multiplier operand (holds a difference)
  localparam int PRW       = 2 * OPW;          // product width
  localparam int SUMW      = PRW + 2;          // sum of three products
  localparam int SQW       = 2 * DW;           // sum of squares handed to the root unit
  localparam int SQ_STEPS  = SQW / 2;          // one root bit per step
  localparam int DIV_W     = DW + FRAC_BITS;   // dividend magnitude width
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  localparam int NPROD     = 6;

  // Command queue between the front and the back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // Register map
  localparam int TOL_W     = 16;
  localparam int PADDR_W   = 3;
  localparam logic REG_TOLERANCE = 1'b0;       // register index, paddr[2]
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam logic [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] MAXW = $signed({{(SUMW-DW){1'b0}}, S32_MAX});
  localparam logic signed [SUMW-1:0] MINW = $signed({{(SUMW-DW){1'b1}}, S32_MIN});
  localparam logic signed [SUMW-1:0] HALF_W = SUMW'(64'd1 << (FRAC_BITS - 1));

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_SCALE   = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_EQ      = 4'd4,
    CMD_DOT     = 4'd5,
    CMD_CROSS   = 4'd6,
    CMD_DIST2   = 4'd7,
    CMD_DIST    = 4'd8,
    CMD_LEN2    = 4'd9,
    CMD_LEN     = 4'd10,
    CMD_NORM    = 4'd11,
    CMD_AXSCALE = 4'd12,
    CMD_ISZERO  = 4'd13,
    CMD_PROJECT = 4'd14
  } cmd_t;

  localparam logic [1:0] AXIS_DROP_X = 2'd0;
  localparam logic [1:0] AXIS_DROP_Y = 2'd1;

  // One queued command with its operands
  typedef struct packed {
    logic [3:0]          cmd;
    logic                is_long;
    logic [2:0][DW-1:0]  a;
    logic [2:0][DW-1:0]  b;
    logic [DW-1:0]       s;
    logic [1:0]          axis;
  } item_t;

  // One result
  typedef struct packed {
    logic [2:0][DW-1:0] v;
    logic [DW-1:0]      sc;
    logic               flag;
    logic               sat;
  } res_t;

  // Work handed from the pipeline to the iterative unit
  typedef struct packed {
    logic [3:0]         cmd;
    logic [2:0][DW-1:0] a;
    logic [DW-1:0]      s;
    logic [SQW-1:0]     sumsq;
    logic               sum_ovf;
  } launch_t;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          clip;
  } sat_t;

  // Clip a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [SUMW-1:0] v);
    sat_t r;
    r.v    = v[DW-1:0];
    r.clip = 1'b0;
    if (v > MAXW) begin
      r.v    = S32_MAX;
      r.clip = 1'b1;
    end else if (v < MINW) begin
      r.v    = S32_MIN;
      r.clip = 1'b1;
    end
    return r;
  endfunction

  // Drop the fraction bits, round to nearest, ties upward
  function automatic logic signed [SUMW-1:0] rnd_fx(input logic signed [SUMW-1:0] v);
    return (v + HALF_W) >>> FRAC_BITS;
  endfunction

endpackage

// ===== sv/vector3_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level: APB register, command queue, pipelined back end and iterative unit.
// Most commands reach done through the queue and the back-end pipeline; div, dist, len
// and norm also pass through the iterative unit.
// Throughput: one command per cycle, set by the three-stage multiply pipeline; a
// div, dist, len or norm holds later commands until its iterative unit finishes.
// Reset is synchronous: it empties the queue, idles the units and sets tolerance to 1.
module vector3_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  command,
  input  logic signed [31:0]          a_x,
  input  logic signed [31:0]          a_y,
  input  logic signed [31:0]          a_z,
  input  logic signed [31:0]          b_x,
  input  logic signed [31:0]          b_y,
  input  logic signed [31:0]          b_z,
  input  logic signed [31:0]          scalar_in,
  input  logic [1:0]                  axis,
  output logic                        done,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y,
  output logic signed [31:0]          out_z,
  output logic signed [31:0]          out_scalar,
  output logic                        out_flag,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [v3a_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import v3a_pkg::*;

  logic [TOL_W-1:0] tolerance;
  logic             head_valid;
  item_t            head;
  logic             pop;
  logic             long_pending;
  logic             dp_res_valid;
  res_t             dp_res;
  logic             launch_valid;
  launch_t          launch;
  logic             it_res_valid;
  res_t             it_res;
  res_t             out_r;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(32 - TOL_W){1'b0}}, tolerance} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  v3a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .scalar_in  (scalar_in),
    .axis       (axis),
    .busy       (busy),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Issue in order; hold while a long command is in flight
  assign pop = head_valid && !long_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_pending <= 1'b0;
    end else if (pop && head.is_long) begin
      long_pending <= 1'b1;
    end else if (it_res_valid) begin
      long_pending <= 1'b0;
    end
  end

  v3a_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pop),
    .in_item      (head),
    .tol          (tolerance),
    .res_valid    (dp_res_valid),
    .res          (dp_res),
    .launch_valid (launch_valid),
    .launch       (launch)
  );

  v3a_iter u_iter (
    .clk          (clk),
    .rst          (rst),
    .launch_valid (launch_valid),
    .launch       (launch),
    .tol          (tolerance),
    .res_valid    (it_res_valid),
    .res          (it_res)
  );

  // Output register; the two sources never finish in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dp_res_valid || it_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_res_valid) begin
      out_r <= dp_res;
    end else if (it_res_valid) begin
      out_r <= it_res;
    end
  end

  assign out_x      = out_r.v[0];
  assign out_y      = out_r.v[1];
  assign out_z      = out_r.v[2];
  assign out_scalar = out_r.sc;
  assign out_flag   = out_r.flag;
  assign saturated  = out_r.sat;

endmodule

// ===== sv/v3a_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts commands, classifies them and queues them for the back end.
module v3a_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [3:0]            command,
  input  logic signed [31:0]    a_x,
  input  logic signed [31:0]    a_y,
  input  logic signed [31:0]    a_z,
  input  logic signed [31:0]    b_x,
  input  logic signed [31:0]    b_y,
  input  logic signed [31:0]    b_z,
  input  logic signed [31:0]    scalar_in,
  input  logic [1:0]            axis,
  output logic                  busy,
  input  logic                  pop,
  output logic                  head_valid,
  output v3a_pkg::item_t        head
);
  import v3a_pkg::*;

  item_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              is_long;
  item_t             entry;

  assign busy       = (count == (QPTR_W + 1)'(QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  // Mark commands that need the iterative unit
  always_comb begin
    unique case (command) inside
      CMD_DIV, CMD_DIST, CMD_LEN, CMD_NORM: is_long = 1'b1;
      default:                              is_long = 1'b0;
    endcase
  end

  always_comb begin
    entry.cmd     = command;
    entry.is_long = is_long;
    entry.a       = {a_z, a_y, a_x};
    entry.b       = {b_z, b_y, b_x};
    entry.s       = scalar_in;
    entry.axis    = axis;
  end

  // Store on transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/v3a_datapath.sv =====
`timescale 1ns / 1ps
// Back-end pipeline: operand select, six multipliers, then sum, round and clip.
module v3a_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  v3a_pkg::item_t            in_item,
  input  logic [v3a_pkg::TOL_W-1:0] tol,
  output logic                      res_valid,
  output v3a_pkg::res_t             res,
  output logic                      launch_valid,
  output v3a_pkg::launch_t          launch
);
  import v3a_pkg::*;

  logic signed [OPW-1:0]  ax [3];
  logic signed [OPW-1:0]  bx [3];
  logic signed [OPW-1:0]  dx [3];
  logic signed [OPW-1:0]  sx;
  logic signed [OPW-1:0]  o0 [NPROD];
  logic signed [OPW-1:0]  o1 [NPROD];

  logic                   va;
  item_t                  it_a;
  logic signed [OPW-1:0]  op0_a [NPROD];
  logic signed [OPW-1:0]  op1_a [NPROD];

  logic                   vb;
  item_t                  it_b;
  logic signed [PRW-1:0]  p_b [NPROD];

  logic signed [SUMW-1:0] pw [NPROD];
  logic signed [SUMW-1:0] sum3;
  logic signed [SUMW-1:0] crw [3];
  logic signed [SUMW-1:0] addw [3];
  logic signed [SUMW-1:0] subw [3];
  logic signed [OPW-1:0]  dbx [3];
  logic [OPW-1:0]         absd [3];
  logic [DW-1:0]          absa [3];
  sat_t                   add_s [3];
  sat_t                   sub_s [3];
  sat_t                   mul_s [3];
  sat_t                   cr_s [3];
  sat_t                   sum_s;
  logic                   eq_flag;
  logic                   zero_flag;
  res_t                   res_c;
  launch_t                launch_c;

  // Select multiplier operands per command
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = OPW'($signed(in_item.a[i]));
      bx[i] = OPW'($signed(in_item.b[i]));
      dx[i] = ax[i] - bx[i];
    end
    sx = OPW'($signed(in_item.s));
    for (int k = 0; k < NPROD; k++) begin
      o0[k] = '0;
      o1[k] = '0;
    end
    case (in_item.cmd) inside
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          o0[i] = ax[i];
          o1[i] = sx;
        end
      end
      CMD_CROSS: begin
        o0[0] = ax[1]; o1[0] = bx[2];
        o0[1] = ax[2]; o1[1] = bx[1];
        o0[2] = ax[2]; o1[2] = bx[0];
        o0[3] = ax[0]; o1[3] = bx[2];
        o0[4] = ax[0]; o1[4] = bx[1];
        o0[5] = ax[1]; o1[5] = bx[0];
      end
      CMD_DIST2, CMD_DIST: begin
        for (int i = 0; i < 3; i++) begin
          o0[i] = dx[i];
          o1[i] = dx[i];
        end
      end
      CMD_LEN2, CMD_LEN, CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          o0[i] = ax[i];
          o1[i] = ax[i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          o0[i] = ax[i];
          o1[i] = bx[i];
        end
      end
    endcase
  end

  // Stage A: operands
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    it_a <= in_item;
    for (int k = 0; k < NPROD; k++) begin
      op0_a[k] <= o0[k];
      op1_a[k] <= o1[k];
    end
  end

  // Stage B: products
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    it_b <= it_a;
    for (int k = 0; k < NPROD; k++) begin
      p_b[k] <= op0_a[k] * op1_a[k];
    end
  end

  // Sums, rounding and clipping of every candidate
  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      pw[k] = SUMW'(p_b[k]);
    end
    sum3   = pw[0] + pw[1] + pw[2];
    crw[0] = pw[0] - pw[1];
    crw[1] = pw[2] - pw[3];
    crw[2] = pw[4] - pw[5];
    for (int i = 0; i < 3; i++) begin
      addw[i]  = SUMW'($signed(it_b.a[i])) + SUMW'($signed(it_b.b[i]));
      subw[i]  = SUMW'($signed(it_b.a[i])) - SUMW'($signed(it_b.b[i]));
      dbx[i]   = OPW'($signed(it_b.a[i])) - OPW'($signed(it_b.b[i]));
      absd[i]  = dbx[i][OPW-1] ? OPW'(-dbx[i]) : OPW'(dbx[i]);
      absa[i]  = it_b.a[i][DW-1] ? DW'(-it_b.a[i]) : it_b.a[i];
      add_s[i] = sat32(addw[i]);
      sub_s[i] = sat32(subw[i]);
      mul_s[i] = sat32(rnd_fx(pw[i]));
      cr_s[i]  = sat32(rnd_fx(crw[i]));
    end
    sum_s     = sat32(rnd_fx(sum3));
    eq_flag   = 1'b1;
    zero_flag = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (absd[i] >= OPW'(tol)) eq_flag = 1'b0;
      if (absa[i] >= DW'(tol))  zero_flag = 1'b0;
    end
  end

  // Pick the result of the command
  always_comb begin
    res_c = '0;
    case (it_b.cmd) inside
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) res_c.v[i] = add_s[i].v;
        res_c.sat = add_s[0].clip | add_s[1].clip | add_s[2].clip;
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) res_c.v[i] = sub_s[i].v;
        res_c.sat = sub_s[0].clip | sub_s[1].clip | sub_s[2].clip;
      end
      CMD_SCALE, CMD_AXSCALE: begin
        for (int i = 0; i < 3; i++) res_c.v[i] = mul_s[i].v;
        res_c.sat = mul_s[0].clip | mul_s[1].clip | mul_s[2].clip;
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) res_c.v[i] = cr_s[i].v;
        res_c.sat = cr_s[0].clip | cr_s[1].clip | cr_s[2].clip;
      end
      CMD_DOT, CMD_DIST2, CMD_LEN2: begin
        res_c.sc  = sum_s.v;
        res_c.sat = sum_s.clip;
      end
      CMD_EQ:     res_c.flag = eq_flag;
      CMD_ISZERO: res_c.flag = zero_flag;
      CMD_PROJECT: begin
        if (it_b.axis == AXIS_DROP_X) begin
          res_c.v[0] = it_b.a[1];
          res_c.v[1] = it_b.a[2];
        end else if (it_b.axis == AXIS_DROP_Y) begin
          res_c.v[0] = it_b.a[0];
          res_c.v[1] = it_b.a[2];
        end else begin
          res_c.v[0] = it_b.a[0];
          res_c.v[1] = it_b.a[1];
        end
      end
      default: res_c = '0;
    endcase
  end

  always_comb begin
    launch_c.cmd     = it_b.cmd;
    launch_c.a       = it_b.a;
    launch_c.s       = it_b.s;
    launch_c.sumsq   = sum3[SQW-1:0];
    launch_c.sum_ovf = |sum3[SUMW-1:SQW];
  end

  // Stage C: result or hand-off to the iterative unit
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      launch_valid <= 1'b0;
    end else begin
      res_valid    <= vb && !it_b.is_long;
      launch_valid <= vb && it_b.is_long;
    end
  end

  always_ff @(posedge clk) begin
    res    <= res_c;
    launch <= launch_c;
  end

endmodule

// ===== sv/v3a_iter.sv =====
`timescale 1ns / 1ps
// Iterative unit: bit-serial square root and three-lane restoring divider.
module v3a_iter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      launch_valid,
  input  v3a_pkg::launch_t          launch,
  input  logic [v3a_pkg::TOL_W-1:0] tol,
  output logic                      res_valid,
  output v3a_pkg::res_t             res
);
  import v3a_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SQRT  = 5'b00010,
    ST_SQFIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DVFIN = 5'b10000
  } state_t;

  localparam logic [DCNT_W-1:0] SQ_LAST  = DCNT_W'(SQ_STEPS - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

  state_t              state, state_next;
  logic [DCNT_W-1:0]   cnt, cnt_next;
  logic [3:0]          cmd, cmd_next;
  logic [2:0][DW-1:0]  a_r, a_next;
  logic [SQW-1:0]      sq_val, sq_val_next;
  logic [DW+1:0]       sq_rem, sq_rem_next;
  logic [DW-1:0]       root, root_next;
  logic [DW:0]         den, den_next;
  logic [DIV_W-1:0]    dv [3];
  logic [DIV_W-1:0]    dv_next [3];
  logic [DW:0]         drem [3];
  logic [DW:0]         drem_next [3];
  logic [2:0]          neg, neg_next;
  res_t                res_next;
  logic                res_valid_next;

  logic [DW+3:0]       sq_try;
  logic [DW+3:0]       sq_trial;
  logic                sq_ge;
  logic [DW:0]         rroot;
  logic                norm_ok;
  logic [DW-1:0]       abs_s;
  logic                div_ok;
  logic [2:0][DW-1:0]  a_src;
  logic [DW-1:0]       mag [3];
  logic [DW+1:0]       dtry [3];
  logic                dge [3];
  logic                load_div;
  logic [DW:0]         load_den;
  logic                load_dneg;
  logic [2:0]          qclip;
  logic [DW-1:0]       qval [3];

  // One root bit per step
  always_comb begin
    sq_try   = {sq_rem, sq_val[SQW-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge    = (sq_try >= sq_trial);
    rroot    = {1'b0, root} + (DW + 1)'(sq_rem > {2'b00, root});
    norm_ok  = (rroot != '0) && (rroot >= (DW + 1)'(tol));
  end

  // Divisor guard and operand magnitudes
  always_comb begin
    abs_s  = launch.s[DW-1] ? DW'(-launch.s) : launch.s;
    div_ok = (launch.s != '0) && (abs_s >= DW'(tol));
    a_src  = (state == ST_IDLE) ? launch.a : a_r;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = a_src[i][DW-1] ? DW'(-a_src[i]) : a_src[i];
      dtry[i] = {drem[i], dv[i][DIV_W-1]};
      dge[i]  = (dtry[i] >= {1'b0, den});
    end
  end

  // Sign and clip of the quotients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg[i]) begin
        qclip[i] = (|dv[i][DIV_W-1:DW]) || (dv[i][DW-1] && (|dv[i][DW-2:0]));
        qval[i]  = qclip[i] ? S32_MIN : DW'(-dv[i][DW-1:0]);
      end else begin
        qclip[i] = |dv[i][DIV_W-1:DW-1];
        qval[i]  = qclip[i] ? S32_MAX : dv[i][DW-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd_next       = cmd;
    a_next         = a_r;
    sq_val_next    = sq_val;
    sq_rem_next    = sq_rem;
    root_next      = root;
    den_next       = den;
    neg_next       = neg;
    res_next       = res;
    res_valid_next = 1'b0;
    load_div       = 1'b0;
    load_den       = '0;
    load_dneg      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dv_next[i]   = dv[i];
      drem_next[i] = drem[i];
    end
    unique case (state)
      ST_IDLE: begin
        if (launch_valid) begin
          cmd_next = launch.cmd;
          a_next   = launch.a;
          res_next = '0;
          if (launch.cmd == CMD_DIV) begin
            if (div_ok) begin
              load_div  = 1'b1;
              load_den  = {1'b0, abs_s};
              load_dneg = launch.s[DW-1];
            end else begin
              res_valid_next = 1'b1;
            end
          end else if (launch.sum_ovf) begin
            res_next.sc    = S32_MAX;
            res_next.sat   = 1'b1;
            res_valid_next = 1'b1;
          end else begin
            sq_val_next = launch.sumsq;
            sq_rem_next = '0;
            root_next   = '0;
            cnt_next    = '0;
            state_next  = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        sq_val_next = {sq_val[SQW-3:0], 2'b00};
        sq_rem_next = sq_ge ? (DW + 2)'(sq_try - sq_trial) : sq_try[DW+1:0];
        root_next   = {root[DW-2:0], sq_ge};
        cnt_next    = cnt + 1'b1;
        if (cnt == SQ_LAST) begin
          state_next = ST_SQFIN;
        end
      end
      ST_SQFIN: begin
        if (cmd == CMD_NORM) begin
          if (norm_ok) begin
            load_div = 1'b1;
            load_den = rroot;
          end else begin
            res_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          if (rroot[DW] || rroot[DW-1]) begin
            res_next.sc  = S32_MAX;
            res_next.sat = 1'b1;
          end else begin
            res_next.sc = rroot[DW-1:0];
          end
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          drem_next[i] = dge[i] ? (DW + 1)'(dtry[i] - {1'b0, den}) : dtry[i][DW:0];
          dv_next[i]   = {dv[i][DIV_W-2:0], dge[i]};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_DVFIN;
        end
      end
      ST_DVFIN: begin
        for (int i = 0; i < 3; i++) res_next.v[i] = qval[i];
        res_next.sat   = |qclip;
        res_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    // Load the divider with |a| * 2^FRAC_BITS on all three lanes
    if (load_div) begin
      den_next   = load_den;
      cnt_next   = '0;
      state_next = ST_DIV;
      for (int i = 0; i < 3; i++) begin
        neg_next[i]  = a_src[i][DW-1] ^ load_dneg;
        dv_next[i]   = {mag[i], {FRAC_BITS{1'b0}}};
        drem_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    cmd    <= cmd_next;
    a_r    <= a_next;
    sq_val <= sq_val_next;
    sq_rem <= sq_rem_next;
    root   <= root_next;
    den    <= den_next;
    neg    <= neg_next;
    res    <= res_next;
    for (int i = 0; i < 3; i++) begin
      dv[i]   <= dv_next[i];
      drem[i] <= drem_next[i];
    end
  end

endmodule

// ===== sv/v3a_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the vector arithmetic unit, bound to the top level.
module v3a_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        done,
  input logic signed [31:0]          out_x,
  input logic signed [31:0]          out_y,
  input logic signed [31:0]          out_z,
  input logic signed [31:0]          out_scalar,
  input logic                        out_flag,
  input logic                        saturated,
  input logic [v3a_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                 prdata
);

  // No result transfer right after reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Queue is empty right after reset
  a_idle_after_rst: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  // Tolerance reads back its reset value
  a_tol_reset: assert property (@(posedge clk) rst |=> (paddr[2] || prdata == 32'd1))
    else $error("tolerance not at reset value");

  // A compare outcome carries no vector, scalar or clip
  a_flag_alone: assert property (@(posedge clk) disable iff (rst)
    (done && out_flag) |-> (out_x == 0 && out_y == 0 && out_z == 0 &&
                            out_scalar == 0 && !saturated))
    else $error("flag result with other fields set");

endmodule

bind vector3_arithmetic_unit v3a_checker u_v3a_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .done       (done),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_z      (out_z),
  .out_scalar (out_scalar),
  .out_flag   (out_flag),
  .saturated  (saturated),
  .paddr      (paddr),
  .prdata     (prdata)
);
